FILE: design/pswrt_pkg.sv
// ----------------------------------------------------------------------------
// pswrt_pkg
// Shared constants and controller/datapath interface types for the
// per-source window rate tracker.
// ----------------------------------------------------------------------------
package pswrt_pkg;

	// default table depth
	localparam int TABLE_ENTRIES_DEF = 16;

	// field widths
	localparam int ADDR_W   = 32;
	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 16;
	localparam int SLOT_W   = 4;
	localparam int OCC_W    = 5;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b1;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] WINDOW_RST = 16'd60;
	localparam logic [CFG_DATA_W-1:0] THRESH_RST = 16'd100;

	// saturation limit of an entry count
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// controller -> datapath commands
	typedef struct packed {
		logic load;    // latch the item, clear the scan trackers
		logic issue;   // read the next table entry
		logic update;  // write back the chosen entry, register the result
	} pswrt_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic last_issue;  // the read being issued is the last entry
	} pswrt_stat_t;

endpackage

FILE: design/per_source_window_rate_tracker.sv
// Each item is accepted in idle; the table is then read one entry per cycle through
// the single read port, followed by a drain state and a write-back state, and done is
// registered from the write-back. A new item is not accepted while busy.
// A new item may be accepted in the cycle that shows the result; results cannot stall.
// Reset (arst_n low) clears all valid bits, the occupancy count and the sequencer at once,
// and restores window_seconds = 60, count_threshold = 100.
// ----------------------------------------------------------------------------
// per_source_window_rate_tracker
// Fixed-window packet counter per source address with oldest-start eviction.
// ----------------------------------------------------------------------------
module per_source_window_rate_tracker #(
	parameter int TABLE_ENTRIES = pswrt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [pswrt_pkg::ADDR_W-1:0]        src_addr,
	input  logic [pswrt_pkg::TIME_W-1:0]        now_seconds,
	input  logic                                cfg_we,
	input  logic [pswrt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pswrt_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                done,
	output logic                                over_threshold,
	output logic [pswrt_pkg::COUNT_W-1:0]       src_count,
	output logic [pswrt_pkg::SLOT_W-1:0]        slot_index,
	output logic                                new_entry,
	output logic                                evicted,
	output logic [pswrt_pkg::OCC_W-1:0]         occupancy
);
	import pswrt_pkg::*;

	pswrt_cmd_t  cmd;
	pswrt_stat_t stat;

	// sequencer
	pswrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// table and update logic
	pswrt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.src_addr       (src_addr),
		.now_seconds    (now_seconds),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.done           (done),
		.over_threshold (over_threshold),
		.src_count      (src_count),
		.slot_index     (slot_index),
		.new_entry      (new_entry),
		.evicted        (evicted),
		.occupancy      (occupancy)
	);

endmodule

FILE: design/pswrt_ctrl.sv
// ----------------------------------------------------------------------------
// pswrt_ctrl
// Sequencer: accepts an item, walks the table once, drains the read
// pipeline and triggers the write-back.
// ----------------------------------------------------------------------------
module pswrt_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  pswrt_pkg::pswrt_stat_t  stat,
	output pswrt_pkg::pswrt_cmd_t   cmd,
	output logic                    busy
);
	import pswrt_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// next state and commands
	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (stat.last_issue) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nxt  = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

FILE: design/pswrt_dp.sv
// ----------------------------------------------------------------------------
// pswrt_dp
// Datapath: entry memories, valid bits, scan trackers (hit, first empty,
// oldest start), window/saturation update and result registers.
// ----------------------------------------------------------------------------
module pswrt_dp #(
	parameter int TABLE_ENTRIES = pswrt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pswrt_pkg::pswrt_cmd_t               cmd,
	output pswrt_pkg::pswrt_stat_t              stat,
	input  logic [pswrt_pkg::ADDR_W-1:0]        src_addr,
	input  logic [pswrt_pkg::TIME_W-1:0]        now_seconds,
	input  logic                                cfg_we,
	input  logic [pswrt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pswrt_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                done,
	output logic                                over_threshold,
	output logic [pswrt_pkg::COUNT_W-1:0]       src_count,
	output logic [pswrt_pkg::SLOT_W-1:0]        slot_index,
	output logic                                new_entry,
	output logic                                evicted,
	output logic [pswrt_pkg::OCC_W-1:0]         occupancy
);
	import pswrt_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	// configuration registers
	logic [CFG_DATA_W-1:0] window_q;
	logic [CFG_DATA_W-1:0] thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			thresh_q <= THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW: window_q <= cfg_data;
				CFG_THRESH: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// entry storage
	logic [ADDR_W-1:0]  mem_addr  [TABLE_ENTRIES];
	logic [TIME_W-1:0]  mem_start [TABLE_ENTRIES];
	logic [COUNT_W-1:0] mem_count [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CW-1:0]            total_q;

	// latched item
	logic [ADDR_W-1:0] key_addr_q;
	logic [TIME_W-1:0] key_now_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_addr_q <= src_addr;
			key_now_q  <= now_seconds;
		end
	end

	// read index
	logic [IW-1:0] rd_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.load) begin
			rd_idx_q <= '0;
		end else if (cmd.issue) begin
			rd_idx_q <= rd_idx_q + IW'(1);
		end
	end

	assign stat.last_issue = (rd_idx_q == LAST_IDX);

	// registered memory read
	logic [ADDR_W-1:0]  rd_addr_s1;
	logic [TIME_W-1:0]  rd_start_s1;
	logic [COUNT_W-1:0] rd_count_s1;
	logic [IW-1:0]      rd_slot_s1;
	logic               rd_vld_s1;

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_addr_s1  <= mem_addr[rd_idx_q];
			rd_start_s1 <= mem_start[rd_idx_q];
			rd_count_s1 <= mem_count[rd_idx_q];
			rd_slot_s1  <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
		end
	end

	// per-entry evaluation
	logic ent_valid;
	logic ent_hit;
	logic ent_empty;
	logic ent_older;

	assign ent_valid = valid_q[rd_slot_s1];
	assign ent_hit   = rd_vld_s1 && ent_valid && (rd_addr_s1 == key_addr_q);
	assign ent_empty = rd_vld_s1 && !ent_valid;

	// scan trackers
	logic               hit_found_q;
	logic [IW-1:0]      hit_idx_q;
	logic [TIME_W-1:0]  hit_start_q;
	logic [COUNT_W-1:0] hit_count_q;
	logic               empty_found_q;
	logic [IW-1:0]      empty_idx_q;
	logic [TIME_W-1:0]  min_start_q;
	logic [IW-1:0]      min_idx_q;

	// strict less-than keeps the lowest index on ties
	assign ent_older = rd_vld_s1 && ((rd_slot_s1 == '0) || (rd_start_s1 < min_start_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (cmd.load) begin
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
		end else begin
			if (ent_hit) begin
				hit_found_q <= 1'b1;
			end
			if (ent_empty) begin
				empty_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ent_hit && !hit_found_q) begin
			hit_idx_q   <= rd_slot_s1;
			hit_start_q <= rd_start_s1;
			hit_count_q <= rd_count_s1;
		end
		if (ent_empty && !empty_found_q) begin
			empty_idx_q <= rd_slot_s1;
		end
		if (ent_older) begin
			min_start_q <= rd_start_s1;
			min_idx_q   <= rd_slot_s1;
		end
	end

	// entry update
	logic [TIME_W-1:0]  elapsed;
	logic               in_window;
	logic [COUNT_W-1:0] inc_count;
	logic [IW-1:0]      upd_slot;
	logic [COUNT_W-1:0] upd_count;
	logic [TIME_W-1:0]  upd_start;
	logic               upd_new;
	logic               upd_evict;
	logic               upd_grow;
	logic [CW-1:0]      total_nxt;

	assign elapsed   = key_now_q - hit_start_q;
	assign in_window = (elapsed <= {{(TIME_W-CFG_DATA_W){1'b0}}, window_q});
	assign inc_count = (hit_count_q == COUNT_MAX) ? hit_count_q : hit_count_q + COUNT_W'(1);

	always_comb begin
		upd_slot  = min_idx_q;
		upd_count = COUNT_W'(1);
		upd_start = key_now_q;
		upd_new   = 1'b1;
		upd_evict = 1'b0;
		upd_grow  = 1'b0;
		priority if (hit_found_q) begin
			upd_slot = hit_idx_q;
			upd_new  = 1'b0;
			if (in_window) begin
				upd_count = inc_count;
				upd_start = hit_start_q;
			end
		end else if (empty_found_q) begin
			upd_slot = empty_idx_q;
			upd_grow = 1'b1;
		end else begin
			upd_evict = 1'b1;
		end
	end

	assign total_nxt = upd_grow ? total_q + CW'(1) : total_q;

	// memory write-back
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem_addr[upd_slot]  <= key_addr_q;
			mem_start[upd_slot] <= upd_start;
			mem_count[upd_slot] <= upd_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
		end else if (cmd.update) begin
			valid_q[upd_slot] <= 1'b1;
			total_q           <= total_nxt;
		end
	end

	// result registers
	logic [IW+SLOT_W-1:0] slot_ext;
	logic [CW+OCC_W-1:0]  occ_ext;
	logic                 res_over_q;
	logic [COUNT_W-1:0]   res_count_q;
	logic [SLOT_W-1:0]    res_slot_q;
	logic                 res_new_q;
	logic                 res_evict_q;
	logic [OCC_W-1:0]     res_occ_q;
	logic                 done_q;

	assign slot_ext = {{SLOT_W{1'b0}}, upd_slot};
	assign occ_ext  = {{OCC_W{1'b0}}, total_nxt};

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_over_q  <= (upd_count > thresh_q);
			res_count_q <= upd_count;
			res_slot_q  <= slot_ext[SLOT_W-1:0];
			res_new_q   <= upd_new;
			res_evict_q <= upd_evict;
			res_occ_q   <= occ_ext[OCC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update;
		end
	end

	assign done           = done_q;
	assign over_threshold = res_over_q;
	assign src_count      = res_count_q;
	assign slot_index     = res_slot_q;
	assign new_entry      = res_new_q;
	assign evicted        = res_evict_q;
	assign occupancy      = res_occ_q;

endmodule

FILE: design/pswrt_checker.sv
// ----------------------------------------------------------------------------
// pswrt_checker
// Port-level checks of the rate tracker, bound to the top level.
// ----------------------------------------------------------------------------
module pswrt_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                done,
	input logic [pswrt_pkg::COUNT_W-1:0]       src_count,
	input logic                                new_entry,
	input logic                                evicted,
	input logic [pswrt_pkg::OCC_W-1:0]         occupancy
);
	import pswrt_pkg::*;

	// an accepted item keeps the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// the result shows while the block is already idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// eviction only happens on allocation
	a_evict_new: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted) |-> new_entry)
		else $error("eviction without allocation");

	// fresh entry starts at count one in an occupied table
	a_new_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && new_entry) |-> (src_count == COUNT_W'(1)) && (occupancy != '0))
		else $error("allocated entry with bad count or occupancy");

	// strobes never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held two cycles");

endmodule

bind per_source_window_rate_tracker pswrt_checker u_pswrt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.src_count    (src_count),
	.new_entry    (new_entry),
	.evicted      (evicted),
	.occupancy    (occupancy)
);

FILE: dv/rate_tracker_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rate_tracker_checker
// Watches the item, register and result ports of the rate tracker. Keeps its
// own copy of the source table, predicts one result per accepted packet and
// compares every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module rate_tracker_checker #(
	parameter int TABLE_ENTRIES = pswrt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [pswrt_pkg::ADDR_W-1:0]     src_addr,
	input  logic [pswrt_pkg::TIME_W-1:0]     now_seconds,
	input  logic                             cfg_we,
	input  logic [pswrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pswrt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             done,
	input  logic                             over_threshold,
	input  logic [pswrt_pkg::COUNT_W-1:0]    src_count,
	input  logic [pswrt_pkg::SLOT_W-1:0]     slot_index,
	input  logic                             new_entry,
	input  logic                             evicted,
	input  logic [pswrt_pkg::OCC_W-1:0]      occupancy,
	output int                               mismatch_count,
	output int                               results_pending
);
	import pswrt_pkg::*;

	typedef struct packed {
		logic               over;
		logic [COUNT_W-1:0] count;
		logic [SLOT_W-1:0]  slot;
		logic               is_new;
		logic               evict;
		logic [OCC_W-1:0]   occ;
	} rate_result_t;

	// shadow of the source table and registers
	logic               tbl_valid [TABLE_ENTRIES];
	logic [ADDR_W-1:0]  tbl_addr  [TABLE_ENTRIES];
	logic [TIME_W-1:0]  tbl_start [TABLE_ENTRIES];
	logic [COUNT_W-1:0] tbl_count [TABLE_ENTRIES];
	int                 occ_total;
	logic [CFG_DATA_W-1:0] window_len;
	logic [CFG_DATA_W-1:0] count_limit;

	rate_result_t expected_results [$];
	rate_result_t want_res;
	int           results_checked;

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		$display("%0t ns: result %0d: %s", $time, results_checked, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// one packet through the table: lookup, window test, allocate or evict
	function automatic rate_result_t track_packet(input logic [ADDR_W-1:0] addr,
			input logic [TIME_W-1:0] now_s);
		rate_result_t      res;
		int                pick;
		int                i;
		logic [TIME_W-1:0] elapsed;
		res = '0;
		pick = -1;
		for (i = 0; i < TABLE_ENTRIES; i++)
			if (pick < 0 && tbl_valid[i] && tbl_addr[i] == addr)
				pick = i;

		if (pick >= 0) begin
			// hit: count inside the window, else restart it
			elapsed = now_s - tbl_start[pick];
			if (elapsed <= TIME_W'(window_len)) begin
				if (tbl_count[pick] != COUNT_MAX)
					tbl_count[pick] = tbl_count[pick] + COUNT_W'(1);
			end else begin
				tbl_start[pick] = now_s;
				tbl_count[pick] = COUNT_W'(1);
			end
		end else begin
			// miss: first empty entry, else oldest start (lowest index on ties)
			for (i = 0; i < TABLE_ENTRIES; i++)
				if (pick < 0 && !tbl_valid[i])
					pick = i;
			if (pick >= 0) begin
				if (occ_total < TABLE_ENTRIES)
					occ_total++;
			end else begin
				pick = 0;
				for (i = 1; i < TABLE_ENTRIES; i++)
					if (tbl_start[i] < tbl_start[pick])
						pick = i;
				res.evict = 1'b1;
			end
			res.is_new = 1'b1;
			tbl_valid[pick] = 1'b1;
			tbl_addr[pick]  = addr;
			tbl_start[pick] = now_s;
			tbl_count[pick] = COUNT_W'(1);
		end

		res.count = tbl_count[pick];
		res.over  = tbl_count[pick] > count_limit;
		res.slot  = pick[SLOT_W-1:0];
		res.occ   = occ_total[OCC_W-1:0];
		return res;
	endfunction

	// result check first, then register writes, then the newly accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_valid = '{default: 1'b0};
			tbl_addr  = '{default: '0};
			tbl_start = '{default: '0};
			tbl_count = '{default: '0};
			occ_total = 0;
			window_len = WINDOW_RST;
			count_limit = THRESH_RST;
			expected_results.delete();
			mismatch_count = 0;
			results_checked = 0;
			results_pending <= 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					note_mismatch("result strobe with no packet outstanding");
				end else begin
					want_res = expected_results.pop_front();
					check_field("over_threshold", 32'(over_threshold), 32'(want_res.over));
					check_field("src_count", 32'(src_count), 32'(want_res.count));
					check_field("slot_index", 32'(slot_index), 32'(want_res.slot));
					check_field("new_entry", 32'(new_entry), 32'(want_res.is_new));
					check_field("evicted", 32'(evicted), 32'(want_res.evict));
					check_field("occupancy", 32'(occupancy), 32'(want_res.occ));
					results_checked++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW: window_len = cfg_data;
					CFG_THRESH: count_limit = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				expected_results.push_back(track_packet(src_addr, now_seconds));
			results_pending <= expected_results.size();
		end
	end

endmodule

FILE: dv/tb_per_source_window_rate_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_source_window_rate_tracker
// Drives packet events into the rate tracker: a directed pass over window
// edges, timestamp wrap, table fill and eviction ties, a short run past a low
// threshold, then random phases over address pools and register settings with
// bursty issue. Checking lives in rate_tracker_checker.
// ----------------------------------------------------------------------------
module tb_per_source_window_rate_tracker;
	import pswrt_pkg::*;

	localparam int TABLE_ENTRIES   = TABLE_ENTRIES_DEF;
	localparam int CLK_PERIOD      = 8;
	localparam int RESULT_LATENCY  = TABLE_ENTRIES + 3;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 230;
	localparam int COUNT_RUN_ITEMS = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [ADDR_W-1:0]     src_addr = '0;
	logic [TIME_W-1:0]     now_seconds = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_WINDOW;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  busy;
	logic                  done;
	logic                  over_threshold;
	logic [COUNT_W-1:0]    src_count;
	logic [SLOT_W-1:0]     slot_index;
	logic                  new_entry;
	logic                  evicted;
	logic [OCC_W-1:0]      occupancy;
	int                    mismatch_count;
	int                    results_pending;

	// per-phase address pool and running timestamp
	logic [ADDR_W-1:0] src_pool [32];
	int                pool_size;
	logic [TIME_W-1:0] clock_now;

	always #(CLK_PERIOD / 2) clk = ~clk;

	per_source_window_rate_tracker #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.src_addr(src_addr),
		.now_seconds(now_seconds),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.over_threshold(over_threshold),
		.src_count(src_count),
		.slot_index(slot_index),
		.new_entry(new_entry),
		.evicted(evicted),
		.occupancy(occupancy)
	);

	rate_tracker_checker #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.src_addr(src_addr),
		.now_seconds(now_seconds),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.over_threshold(over_threshold),
		.src_count(src_count),
		.slot_index(slot_index),
		.new_entry(new_entry),
		.evicted(evicted),
		.occupancy(occupancy),
		.mismatch_count(mismatch_count),
		.results_pending(results_pending)
	);

	// present one packet and hold it until the tracker takes it
	task automatic send_packet(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] t);
		start <= 1'b1;
		src_addr <= addr;
		now_seconds <= t;
		do @(posedge clk); while (busy);
	endtask

	// both registers, back to back, tracker idle
	task automatic program_regs(input logic [CFG_DATA_W-1:0] window,
			input logic [CFG_DATA_W-1:0] thresh);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WINDOW;
		cfg_data <= window;
		@(posedge clk);
		cfg_index <= CFG_THRESH;
		cfg_data <= thresh;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_for_results();
		do @(posedge clk); while (results_pending != 0);
	endtask

	// mostly pool addresses with creeping time, some noise and time jumps
	task automatic run_random_phase(input int n_items, input bit gaps_on);
		int                burst_left;
		int                gap;
		int                dice;
		int                k;
		logic [ADDR_W-1:0] addr;
		burst_left = $urandom_range(1, 24);
		for (k = 0; k < n_items; k++) begin
			dice = $urandom_range(0, 99);
			addr = (dice < 90) ? src_pool[$urandom_range(0, pool_size - 1)] : $urandom();
			dice = $urandom_range(0, 99);
			if (dice < 65)
				clock_now += $urandom_range(0, 2);
			else if (dice < 88)
				clock_now += $urandom_range(0, 40);
			else if (dice < 96)
				clock_now += $urandom_range(0, 131071);
			else
				clock_now = $urandom();
			send_packet(addr, clock_now);

			// burst boundary: maybe a gap, now and then a full drain
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = gaps_on ? $urandom_range(0, 25) : 0;
				if ($urandom_range(0, 15) == 0) begin
					start <= 1'b0;
					wait_for_results();
				end else if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		start <= 1'b0;
	endtask

	// run limit, far above the slowest legal run
	initial begin
		#(100_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int p;
		int j;
		int n;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values: window edges and timestamp wrap
		send_packet(32'h0000_0000, 32'd0);
		send_packet(32'h0000_0000, 32'd60);
		send_packet(32'h0000_0000, 32'd61);
		send_packet(32'h0000_0000, 32'd60);
		send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_packet(32'hFFFF_FFFF, 32'd0);
		// fill the rest of the table with tied starts
		for (j = 2; j < TABLE_ENTRIES; j++)
			send_packet(32'h8000_0000 + j, 32'd100);
		// full table: oldest start goes, then lowest index among ties
		send_packet(32'hA5A5_5A5A, 32'd200);
		send_packet(32'h5A5A_A5A5, 32'd200);
		send_packet(32'h0000_0000, 32'd201);
		start <= 1'b0;
		wait_for_results();

		// count run past a low threshold with a zero-length window
		program_regs(16'd0, 16'd3);
		for (n = 0; n < COUNT_RUN_ITEMS; n++)
			send_packet(32'h0F0F_F0F0, 32'h1234_5678);
		start <= 1'b0;
		wait_for_results();

		// random phases over register settings, extremes included
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: program_regs(16'd0, 16'd0);
				1: program_regs(16'hFFFF, 16'hFFFF);
				2: program_regs(16'd2, 16'd3);
				3: program_regs(CFG_DATA_W'($urandom_range(0, 40)),
					CFG_DATA_W'($urandom_range(0, 40)));
				4: program_regs(16'hFFFF, 16'd0);
				5: program_regs(16'd0, 16'hFFFF);
				6: program_regs(16'd10, 16'd6);
				default: program_regs(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
			endcase
			pool_size = (p % 3 == 0) ? 12 : $urandom_range(17, 28);
			for (j = 0; j < pool_size; j++)
				src_pool[j] = $urandom();
			clock_now = (p % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 400) : $urandom();
			run_random_phase(ITEMS_PER_PHASE, p % 3 != 2);
			wait_for_results();
		end

		repeat (RESULT_LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0 && results_pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
